[rtl/core/kct_pkg.sv]
// kct_pkg: shared widths, result status codes, controller/datapath command
// and status structs, and the saturating increment helper
// no dependencies
`default_nettype none

package kct_pkg;

  // fixed field widths of the request and result transactions
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 5;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 6;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ_VALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;

  // request type codes
  localparam logic REQ_TALLY = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic                accept;      // latch request, register match vector
    logic                load_addr;   // capture table read address
    logic                addr_hit;    // read address from matching entry
    logic                insert;      // write new entry at fill position
    logic                drop;        // bump the drop counter
    logic                write_back;  // store incremented counts
    logic                emit;        // load the result register
    logic [STATUS_W-1:0] code;        // status of the emitted result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;   // latched request is a read
    logic hit;       // latched key matches an occupied entry
    logic in_range;  // read index below the fill count
    logic full;      // every entry occupied
    logic out_free;  // result register can take a new result
  } stat_t;

  // counter increment that sticks at all ones
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

[rtl/core/kct_req_if.sv]
// kct_req_if: request channel, valid/ready with tally or read payload
// depends on kct_pkg
`default_nettype none

interface kct_req_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [kct_pkg::KEY_W-1:0] key;
  logic                     flagged;
  logic [kct_pkg::IDX_W-1:0] index;

  modport source (output valid, req_type, key, flagged, index, input ready);
  modport sink   (input valid, req_type, key, flagged, index, output ready);
endinterface

`default_nettype wire

[rtl/core/kct_rsp_if.sv]
// kct_rsp_if: result channel, valid/ready with entry contents and totals
// depends on kct_pkg
`default_nettype none

interface kct_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [kct_pkg::STATUS_W-1:0] status;
  logic [kct_pkg::IDX_W-1:0]    entry_index;
  logic [kct_pkg::KEY_W-1:0]    entry_key;
  logic [kct_pkg::CNT_W-1:0]    entry_count;
  logic [kct_pkg::CNT_W-1:0]    entry_flagged;
  logic [kct_pkg::USED_W-1:0]   used_entries;
  logic [kct_pkg::CNT_W-1:0]    drop_total;

  modport source (output valid, status, entry_index, entry_key, entry_count,
                  entry_flagged, used_entries, drop_total, input ready);
  modport sink   (input valid, status, entry_index, entry_key, entry_count,
                  entry_flagged, used_entries, drop_total, output ready);
endinterface

`default_nettype wire

[rtl/core/kct_ram.sv]
// kct_ram: generic single write port, single read port RAM, registered read
// no dependencies
`default_nettype none

module kct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/core/kct_ctrl.sv]
// kct_ctrl: sequencing state machine for one request at a time
// depends on kct_pkg
`default_nettype none

module kct_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire kct_pkg::stat_t stat,
  output kct_pkg::cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_LOOK = 2'd1;  // match vector registered, decide
  localparam logic [1:0] S_UPD  = 2'd2;  // counts read back, update hit entry
  localparam logic [1:0] S_RDV  = 2'd3;  // entry read back for a read request

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = kct_pkg::ST_HIT;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat.is_read) begin
          if (stat.in_range) begin
            cmd.load_addr = 1'b1;
            state_next    = S_RDV;
          end else if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.code   = kct_pkg::ST_READ_EMPTY;
            state_next = S_IDLE;
          end
        end else if (stat.hit) begin
          cmd.load_addr = 1'b1;
          cmd.addr_hit  = 1'b1;
          state_next    = S_UPD;
        end else if (stat.out_free) begin
          if (stat.full) begin
            cmd.drop = 1'b1;
            cmd.code = kct_pkg::ST_DROPPED;
          end else begin
            cmd.insert = 1'b1;
            cmd.code   = kct_pkg::ST_INSERTED;
          end
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_UPD: begin
        if (stat.out_free) begin
          cmd.write_back = 1'b1;
          cmd.emit       = 1'b1;
          cmd.code       = kct_pkg::ST_HIT;
          state_next     = S_IDLE;
        end
      end
      S_RDV: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.code   = kct_pkg::ST_READ_VALID;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/kct_dp.sv]
// kct_dp: key match bank, counter RAMs, fill and drop counters, result register
// depends on kct_pkg, kct_ram, kct_rsp_if
`default_nettype none

module kct_dp #(
  parameter int CAPACITY = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_req_type,
  input  wire logic [kct_pkg::KEY_W-1:0] in_key,
  input  wire logic                      in_flagged,
  input  wire logic [kct_pkg::IDX_W-1:0] in_index,
  input  wire kct_pkg::cmd_t             cmd,
  output kct_pkg::stat_t                 stat,
  kct_rsp_if.source                      rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = kct_pkg::KEY_W;
  localparam int NW = kct_pkg::CNT_W;

  // latched request
  logic                      r_type;
  logic [KW-1:0]             r_key;
  logic                      r_flag;
  logic [kct_pkg::IDX_W-1:0] r_index;

  // key match bank and fill state
  logic [KW-1:0]       key_bank [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] match_next;
  logic [AW-1:0]       hit_idx;
  logic [CW-1:0]       occupied;
  logic [CW-1:0]       occupied_next;
  logic [NW-1:0]       rejected;
  logic [NW-1:0]       rejected_next;
  logic [AW-1:0]       fill_addr;

  // table RAM access
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] ram_rd_addr;
  logic [AW-1:0] ram_wr_addr;
  logic [KW-1:0] key_rd;
  logic [NW-1:0] cnt_rd;
  logic [NW-1:0] flg_rd;
  logic [NW-1:0] cnt_wr;
  logic [NW-1:0] flg_wr;
  logic [NW-1:0] cnt_inc;
  logic [NW-1:0] flg_inc;
  logic          ram_we;

  // result register
  logic                         out_valid;
  logic [kct_pkg::STATUS_W-1:0] out_status;
  logic [kct_pkg::IDX_W-1:0]    out_index;
  logic [KW-1:0]                out_key;
  logic [NW-1:0]                out_count;
  logic [NW-1:0]                out_flagged;
  logic [kct_pkg::USED_W-1:0]   out_used;
  logic [NW-1:0]                out_drops;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_type  <= in_req_type;
      r_key   <= in_key;
      r_flag  <= in_flagged;
      r_index <= in_index;
    end
  end

  // parallel compare against occupied entries only
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_next[i] = (key_bank[i] == in_key) && (CW'(i) < occupied);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      match <= match_next;
    end
  end

  // one-hot match to index, entries are unique so an or-tree suffices
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | AW'(i);
      end
    end
  end

  // key bank write on insert
  assign fill_addr = AW'(occupied);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      key_bank[fill_addr] <= r_key;
    end
  end

  // fill and drop counters
  assign occupied_next = cmd.insert ? occupied + CW'(1) : occupied;
  assign rejected_next = cmd.drop ? kct_pkg::sat_inc(rejected) : rejected;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
      rejected <= '0;
    end else begin
      occupied <= occupied_next;
      rejected <= rejected_next;
    end
  end

  // status toward the controller
  assign stat.is_read  = (r_type == kct_pkg::REQ_READ);
  assign stat.hit      = |match;
  assign stat.in_range = (32'(r_index) < 32'(occupied));
  assign stat.full     = (occupied == CW'(CAPACITY));
  assign stat.out_free = !out_valid || rsp.ready;

  // read address: new address goes straight to the RAMs, then is held
  assign ram_rd_addr = cmd.load_addr ? (cmd.addr_hit ? hit_idx : AW'(r_index)) : rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.load_addr) begin
      rd_addr <= ram_rd_addr;
    end
  end

  // counter write data for insert or hit update
  assign cnt_inc     = kct_pkg::sat_inc(cnt_rd);
  assign flg_inc     = r_flag ? kct_pkg::sat_inc(flg_rd) : flg_rd;
  assign ram_we      = cmd.insert || cmd.write_back;
  assign ram_wr_addr = cmd.insert ? fill_addr : rd_addr;
  assign cnt_wr      = cmd.insert ? NW'(1) : cnt_inc;
  assign flg_wr      = cmd.insert ? NW'(r_flag) : flg_inc;

  kct_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key_ram (
    .clk     (clk),
    .wr_en   (cmd.insert),
    .wr_addr (fill_addr),
    .wr_data (r_key),
    .rd_addr (ram_rd_addr),
    .rd_data (key_rd)
  );

  kct_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (cnt_wr),
    .rd_addr (ram_rd_addr),
    .rd_data (cnt_rd)
  );

  kct_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_flg_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (flg_wr),
    .rd_addr (ram_rd_addr),
    .rd_data (flg_rd)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload by status
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.code;
      out_used   <= kct_pkg::USED_W'(occupied_next);
      out_drops  <= rejected_next;
      case (cmd.code)
        kct_pkg::ST_HIT: begin
          out_index   <= kct_pkg::IDX_W'(rd_addr);
          out_key     <= r_key;
          out_count   <= cnt_inc;
          out_flagged <= flg_inc;
        end
        kct_pkg::ST_INSERTED: begin
          out_index   <= kct_pkg::IDX_W'(occupied);
          out_key     <= r_key;
          out_count   <= NW'(1);
          out_flagged <= NW'(r_flag);
        end
        kct_pkg::ST_READ_VALID: begin
          out_index   <= r_index;
          out_key     <= key_rd;
          out_count   <= cnt_rd;
          out_flagged <= flg_rd;
        end
        kct_pkg::ST_READ_EMPTY: begin
          out_index   <= r_index;
          out_key     <= '0;
          out_count   <= '0;
          out_flagged <= '0;
        end
        default: begin
          out_index   <= '0;
          out_key     <= '0;
          out_count   <= '0;
          out_flagged <= '0;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.entry_index   = out_index;
  assign rsp.entry_key     = out_key;
  assign rsp.entry_count   = out_count;
  assign rsp.entry_flagged = out_flagged;
  assign rsp.used_entries  = out_used;
  assign rsp.drop_total    = out_drops;

endmodule

`default_nettype wire

[rtl/core/keyed_count_table.sv]
// keyed_count_table: fixed-capacity table of saturating key counters. A tally
// transaction compares its key against all occupied entries at once; a hit
// bumps that entry's count (and flagged count when flagged is set), a miss
// fills the next free entry, and a miss on a full table bumps the drop total.
// A read transaction returns the entry at an index. One request is worked at
// a time: an insert, a drop or an empty-slot read is settled in the look state,
// a hit or an occupied-slot read goes on to the update or read state, because
// the match vector is registered and the counter RAMs have a registered read
// port. A result waits in an output register, and the next request is taken
// while it waits; the block holds only if a new result is ready before the
// previous one has been taken. No clearing pass is needed after reset.
// depends on kct_pkg, kct_req_if, kct_rsp_if, kct_ctrl, kct_dp
`default_nettype none

module keyed_count_table #(
  parameter int CAPACITY = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  kct_req_if.sink   req,
  kct_rsp_if.source rsp
);

  kct_pkg::cmd_t  cmd;
  kct_pkg::stat_t stat;
  logic           ready;

  assign req.ready = ready;

  // sequencer
  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table and counters
  kct_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_req_type (req.req_type),
    .in_key      (req.key),
    .in_flagged  (req.flagged),
    .in_index    (req.index),
    .cmd         (cmd),
    .stat        (stat),
    .rsp         (rsp)
  );

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten");

  // inserts only into a table with room
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> (!stat.full && !stat.hit && !cmd.drop))
    else $error("insert on full table or on a hit");

  // one request in flight: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && ready) |=> !ready)
    else $error("second request accepted while busy");

  // counter write back only with a result
  a_wb_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.write_back |-> (cmd.emit && cmd.code == kct_pkg::ST_HIT))
    else $error("count update without hit result");

endmodule

`default_nettype wire
